/* sv/ffba_pkg.sv */
// Package for the first-fit block allocator: command and status codes,
// table entry and result types, sequencer states and default sizes.
// No dependencies.
`default_nettype none

package ffba_pkg;

    localparam int ADDR_BITS = 20;
    localparam int SIZE_W    = 20;
    localparam int TOP_W     = ADDR_BITS + 1;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 32;

    localparam logic [TOP_W-1:0] HEAP_LIMIT_RESET = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [TOP_W-1:0] ADDR_SPACE       = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMEM   = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [1:0] STAT_ZERO    = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [SIZE_W-1:0]    cap;
        logic                 free;
    } entry_t;

    typedef struct packed {
        logic                 present;
        logic [ADDR_BITS-1:0] address;
        logic [1:0]           status;
        logic                 copy_needed;
        logic [ADDR_BITS-1:0] copy_source;
        logic [SIZE_W-1:0]    copy_length;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_FIT,
        ST_FREE_OLD,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* sv/ffba_req_if.sv */
// Request channel of the allocator: valid/ready plus one command word.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [ffba_pkg::SIZE_W-1:0]    request_size;
    logic                           address_present;
    logic [ffba_pkg::ADDR_BITS-1:0] block_address;

    modport source (output valid, command, request_size, address_present, block_address,
                    input ready);
    modport sink   (input valid, command, request_size, address_present, block_address,
                    output ready);
endinterface

`default_nettype wire

/* sv/ffba_rsp_if.sv */
// Response channel of the allocator: valid/ready plus one result word.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           result_present;
    logic [ffba_pkg::ADDR_BITS-1:0] result_address;
    logic [1:0]                     status;
    logic                           copy_needed;
    logic [ffba_pkg::ADDR_BITS-1:0] copy_source;
    logic [ffba_pkg::SIZE_W-1:0]    copy_length;

    modport source (output valid, result_present, result_address, status, copy_needed,
                    copy_source, copy_length, input ready);
    modport sink   (input valid, result_present, result_address, status, copy_needed,
                    copy_source, copy_length, output ready);
endinterface

`default_nettype wire

/* sv/ffba_table.sv */
// Block table memory: one write port, one read port with registered data.
// Depends on ffba_pkg for the entry type.
`default_nettype none

module ffba_table #(
    parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire ffba_pkg::entry_t         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output ffba_pkg::entry_t              rdata
);

    ffba_pkg::entry_t mem [DEPTH];
    ffba_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/first_fit_block_allocator.sv */
// First-fit block allocator; N is the live entry count (at most MAX_BLOCKS).
// Requests are handled one at a time: the next request is taken in the cycle after the
// result is loaded. The table is read one entry per cycle during a search.
// Reset clears the sequencer, entry count and heap top; heap_limit resets to 2^20.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and ffba_table.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ffba_pkg::TOP_W-1:0]  cfg_wdata,
    ffba_req_if.sink                         req,
    ffba_rsp_if.source                       rsp
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AB = ffba_pkg::ADDR_BITS;
    localparam int SW = ffba_pkg::SIZE_W;
    localparam int TW = ffba_pkg::TOP_W;

    ffba_pkg::state_t  state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [AB-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [TW-1:0]     limit_reg;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic              move_reg, move_next;
    logic [IW-1:0]     old_idx_reg, old_idx_next;
    ffba_pkg::entry_t  old_entry_reg, old_entry_next;
    ffba_pkg::result_t res_reg, res_next;
    ffba_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    ffba_pkg::entry_t  mem_wdata;
    ffba_pkg::entry_t  rd_data;

    logic              issue;
    logic [AB-1:0]     rd_payload;
    logic [AB-1:0]     top_payload;
    logic [TW-1:0]     eff_limit;
    logic [TW:0]       append_end;
    logic              append_ok;

    ffba_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_idx_reg[IW-1:0]),
        .rdata (rd_data)
    );

    assign issue       = (scan_idx_reg < count_reg);
    assign rd_payload  = rd_data.base + AB'(HEADER_BYTES);
    assign top_payload = top_reg[AB-1:0] + AB'(HEADER_BYTES);
    assign eff_limit   = (limit_reg > ffba_pkg::ADDR_SPACE) ? ffba_pkg::ADDR_SPACE : limit_reg;
    assign append_end  = {1'b0, top_reg} + (TW+1)'(HEADER_BYTES) + (TW+1)'(size_reg);
    assign append_ok   = (count_reg < CW'(MAX_BLOCKS)) && (append_end <= {1'b0, eff_limit});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::ST_IDLE;
            count_reg     <= '0;
            top_reg       <= '0;
            limit_reg     <= ffba_pkg::HEAP_LIMIT_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        move_reg      <= move_next;
        old_idx_reg   <= old_idx_next;
        old_entry_reg <= old_entry_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        move_next      = move_reg;
        old_idx_next   = old_idx_reg;
        old_entry_next = old_entry_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_waddr      = pend_idx_reg;
        mem_wdata      = rd_data;
        req.ready      = 1'b0;

        unique case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next      = req.command;
                    size_next     = req.request_size;
                    addr_next     = req.block_address;
                    res_next      = '0;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    move_next     = 1'b0;
                    priority if (req.command == ffba_pkg::CMD_ALLOC ||
                                 (req.command == ffba_pkg::CMD_REALLOC && !req.address_present))
                    begin
                        if (req.request_size == '0)
                        begin
                            res_next.status = ffba_pkg::STAT_ZERO;
                            state_next      = ffba_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = ffba_pkg::ST_FIT;
                        end
                    end
                    else if (req.command == ffba_pkg::CMD_FREE && !req.address_present)
                    begin
                        state_next = ffba_pkg::ST_RESP;
                    end
                    else if (req.command == ffba_pkg::CMD_FREE ||
                             req.command == ffba_pkg::CMD_REALLOC)
                    begin
                        state_next = ffba_pkg::ST_FIND;
                    end
                    else
                    begin
                        state_next = ffba_pkg::ST_RESP;
                    end
                end
            end

            ffba_pkg::ST_FIND:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && rd_payload == addr_reg)
                begin
                    mem_wdata.free = 1'b1;
                    state_next     = ffba_pkg::ST_RESP;
                    priority if (cmd_reg == ffba_pkg::CMD_FREE)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (rd_data.free)
                    begin
                        res_next.status = ffba_pkg::STAT_UNKNOWN;
                    end
                    else if (size_reg == '0)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (rd_data.cap >= size_reg)
                    begin
                        res_next.present = 1'b1;
                        res_next.address = addr_reg;
                    end
                    else
                    begin
                        // block too small: search for a new one, then release this one
                        move_next      = 1'b1;
                        old_idx_next   = pend_idx_reg;
                        old_entry_next = rd_data;
                        scan_idx_next  = '0;
                        pend_next      = 1'b0;
                        state_next     = ffba_pkg::ST_FIT;
                    end
                end
                else if (!pend_reg && !issue)
                begin
                    res_next.status = ffba_pkg::STAT_UNKNOWN;
                    state_next      = ffba_pkg::ST_RESP;
                end
            end

            ffba_pkg::ST_FIT:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && rd_data.free && rd_data.cap >= size_reg)
                begin
                    mem_we           = 1'b1;
                    mem_wdata.free   = 1'b0;
                    res_next.present = 1'b1;
                    res_next.address = rd_payload;
                    state_next       = move_reg ? ffba_pkg::ST_FREE_OLD : ffba_pkg::ST_RESP;
                end
                else if (!pend_reg && !issue)
                begin
                    if (append_ok)
                    begin
                        // no reusable block: append a new one at the heap top
                        mem_we           = 1'b1;
                        mem_waddr        = count_reg[IW-1:0];
                        mem_wdata.base   = top_reg[AB-1:0];
                        mem_wdata.cap    = size_reg;
                        mem_wdata.free   = 1'b0;
                        count_next       = count_reg + CW'(1);
                        top_next         = append_end[TW-1:0];
                        res_next.present = 1'b1;
                        res_next.address = top_payload;
                        state_next = move_reg ? ffba_pkg::ST_FREE_OLD : ffba_pkg::ST_RESP;
                    end
                    else
                    begin
                        res_next.status = ffba_pkg::STAT_NOMEM;
                        state_next      = ffba_pkg::ST_RESP;
                    end
                end
            end

            ffba_pkg::ST_FREE_OLD:
            begin
                mem_we               = 1'b1;
                mem_waddr            = old_idx_reg;
                mem_wdata            = old_entry_reg;
                mem_wdata.free       = 1'b1;
                res_next.copy_needed = 1'b1;
                res_next.copy_source = addr_reg;
                res_next.copy_length = old_entry_reg.cap;
                state_next           = ffba_pkg::ST_RESP;
            end

            ffba_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ffba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_present = out_reg.present;
    assign rsp.result_address = out_reg.address;
    assign rsp.status         = out_reg.status;
    assign rsp.copy_needed    = out_reg.copy_needed;
    assign rsp.copy_source    = out_reg.copy_source;
    assign rsp.copy_length    = out_reg.copy_length;

endmodule

`default_nettype wire

/* tb/first_fit_block_allocator_test.sv */
// Self-checking testbench for first_fit_block_allocator: directed and random
// allocate / free / reallocate traffic against an in-bench table predictor.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and the allocator RTL.
module first_fit_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB           = ffba_pkg::ADDR_BITS;
    localparam int SW           = ffba_pkg::SIZE_W;
    localparam int TW           = ffba_pkg::TOP_W;
    localparam int DEPTH        = ffba_pkg::MAX_BLOCKS_DEF;
    localparam int HDR          = ffba_pkg::HEADER_BYTES_DEF;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 120;

    localparam logic [1:0]    CMD_UNUSED = 2'd3;
    localparam logic [TW-1:0] LIMIT_MAX  = {TW{1'b1}};
    localparam logic [TW-1:0] LIMIT_TINY = 21'd200;
    localparam logic [TW-1:0] LIMIT_LOW  = 21'd4096;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [TW-1:0] cfg_wdata;

    ffba_req_if req_ch();
    ffba_rsp_if rsp_ch();

    first_fit_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predicted heap table
    logic [AB-1:0] blk_base [DEPTH];
    logic [SW-1:0] blk_cap  [DEPTH];
    bit            blk_free [DEPTH];
    int            blk_count;
    logic [TW:0]   top_m;
    logic [TW-1:0] limit_m;

    ffba_pkg::result_t awaited_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [AB-1:0] entry_payload(input int idx);
        entry_payload = blk_base[idx] + AB'(HDR);
    endfunction

    // first fit over the table, else append at the heap top
    function automatic bit take_block(input logic [SW-1:0] size,
                                      output logic [AB-1:0] payload);
        logic [TW:0] lim;
        payload = '0;
        lim = {1'b0, (limit_m > ffba_pkg::ADDR_SPACE) ? ffba_pkg::ADDR_SPACE : limit_m};
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && blk_cap[i] >= size)
            begin
                blk_free[i] = 1'b0;
                payload = entry_payload(i);
                return 1'b1;
            end
        end
        if (blk_count >= DEPTH || top_m + (TW+1)'(HDR) + (TW+1)'(size) > lim)
            return 1'b0;
        blk_base[blk_count] = top_m[AB-1:0];
        blk_cap[blk_count]  = size;
        blk_free[blk_count] = 1'b0;
        payload = entry_payload(blk_count);
        blk_count++;
        top_m = top_m + (TW+1)'(HDR) + (TW+1)'(size);
        return 1'b1;
    endfunction

    function automatic int find_block(input logic [AB-1:0] addr);
        for (int i = 0; i < blk_count; i++)
        begin
            if (entry_payload(i) == addr)
                return i;
        end
        return -1;
    endfunction

    function automatic ffba_pkg::result_t allocator_outcome(input logic [1:0] cmd,
                                                            input logic [SW-1:0] size,
                                                            input logic present,
                                                            input logic [AB-1:0] addr);
        ffba_pkg::result_t r;
        int                idx;
        logic [AB-1:0]     got;
        r = '0;
        if (cmd == ffba_pkg::CMD_ALLOC || (cmd == ffba_pkg::CMD_REALLOC && !present))
        begin
            if (size == 0)
                r.status = ffba_pkg::STAT_ZERO;
            else if (take_block(size, got))
            begin
                r.present = 1'b1;
                r.address = got;
            end
            else
                r.status = ffba_pkg::STAT_NOMEM;
        end
        else if (cmd == ffba_pkg::CMD_FREE)
        begin
            if (present)
            begin
                idx = find_block(addr);
                if (idx < 0)
                    r.status = ffba_pkg::STAT_UNKNOWN;
                else
                    blk_free[idx] = 1'b1;
            end
        end
        else if (cmd == ffba_pkg::CMD_REALLOC)
        begin
            idx = find_block(addr);
            if (idx < 0 || blk_free[idx])
                r.status = ffba_pkg::STAT_UNKNOWN;
            else if (size == 0)
                blk_free[idx] = 1'b1;
            else if (blk_cap[idx] >= size)
            begin
                r.present = 1'b1;
                r.address = addr;
            end
            else if (take_block(size, got))
            begin
                // old block stays in use during the search, freed only on success
                blk_free[idx]  = 1'b1;
                r.present      = 1'b1;
                r.address      = got;
                r.copy_needed  = 1'b1;
                r.copy_source  = addr;
                r.copy_length  = blk_cap[idx];
            end
            else
                r.status = ffba_pkg::STAT_NOMEM;
        end
        return r;
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [SW-1:0] size,
                             input logic present, input logic [AB-1:0] addr);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid           <= 1'b1;
        req_ch.command         <= cmd;
        req_ch.request_size    <= size;
        req_ch.address_present <= present;
        req_ch.block_address   <= addr;
        // result cannot arrive before acceptance, so predict now
        awaited_results.push_back(allocator_outcome(cmd, size, present, addr));
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [TW-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        limit_m = value;
    endtask

    task automatic report(input string what, input ffba_pkg::result_t want,
                          input ffba_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("%0t %s: expected p=%0b a=%h st=%0d cp=%0b src=%h len=%h",
                     $time, what, want.present, want.address, want.status,
                     want.copy_needed, want.copy_source, want.copy_length);
            $display("%0t %s: actual   p=%0b a=%h st=%0d cp=%0b src=%h len=%h",
                     $time, what, got.present, got.address, got.status,
                     got.copy_needed, got.copy_source, got.copy_length);
        end
    endtask

    task automatic check_word();
        ffba_pkg::result_t got;
        ffba_pkg::result_t want;
        got.present     = rsp_ch.result_present;
        got.address     = rsp_ch.result_address;
        got.status      = rsp_ch.status;
        got.copy_needed = rsp_ch.copy_needed;
        got.copy_source = rsp_ch.copy_source;
        got.copy_length = rsp_ch.copy_length;
        if (awaited_results.size() == 0)
        begin
            report("unexpected word", '0, got);
            return;
        end
        want = awaited_results.pop_front();
        if (got.present !== want.present || got.address !== want.address
            || got.status !== want.status || got.copy_needed !== want.copy_needed
            || got.copy_source !== want.copy_source || got.copy_length !== want.copy_length)
            report("mismatch", want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_word();
            rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [SW-1:0] draw_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 70)
            return SW'($urandom_range(1, 64));
        if (pick < 92)
            return SW'($urandom_range(65, 4096));
        return SW'($urandom_range(0, (1 << SW) - 1));
    endfunction

    function automatic logic [AB-1:0] draw_address();
        return AB'($urandom_range(0, (1 << AB) - 1));
    endfunction

    // payload of some table entry, free or in use
    function automatic logic [AB-1:0] live_address();
        if (blk_count == 0)
            return draw_address();
        return entry_payload($urandom_range(0, blk_count - 1));
    endfunction

    task automatic test_empty_heap();
        write_limit('0);
        send_word(ffba_pkg::CMD_ALLOC, 20'd1, 1'b0, '0);
        send_word(ffba_pkg::CMD_ALLOC, '0, 1'b0, '0);
        send_word(ffba_pkg::CMD_REALLOC, '0, 1'b0, '0);
        send_word(ffba_pkg::CMD_FREE, '0, 1'b0, '0);
        send_word(ffba_pkg::CMD_FREE, '1, 1'b1, '1);
        send_word(CMD_UNUSED, '1, 1'b1, '1);
    endtask

    task automatic test_alloc_free();
        write_limit(LIMIT_TINY);
        send_word(ffba_pkg::CMD_ALLOC, 20'd1, 1'b0, '0);
        send_word(ffba_pkg::CMD_ALLOC, 20'd100, 1'b0, '0);
        // does not fit under the limit
        send_word(ffba_pkg::CMD_ALLOC, 20'd10, 1'b0, '0);
        send_word(ffba_pkg::CMD_FREE, '0, 1'b1, entry_payload(0));
        send_word(ffba_pkg::CMD_FREE, '0, 1'b1, entry_payload(0));
        send_word(ffba_pkg::CMD_ALLOC, 20'd1, 1'b0, '0);
    endtask

    task automatic test_realloc();
        send_word(ffba_pkg::CMD_REALLOC, 20'd5, 1'b0, '0);
        send_word(ffba_pkg::CMD_REALLOC, 20'd50, 1'b1, entry_payload(1));
        send_word(ffba_pkg::CMD_REALLOC, 20'd150, 1'b1, entry_payload(1));
        send_word(ffba_pkg::CMD_REALLOC, 20'd4, 1'b1, entry_payload(1) + AB'(1));
        send_word(ffba_pkg::CMD_FREE, '0, 1'b1, entry_payload(0));
        send_word(ffba_pkg::CMD_REALLOC, 20'd4, 1'b1, entry_payload(0));
        send_word(ffba_pkg::CMD_REALLOC, '0, 1'b1, entry_payload(1));
        send_word(ffba_pkg::CMD_REALLOC, 20'd3, 1'b0, '0);
    endtask

    task automatic test_wide_limit();
        write_limit(LIMIT_MAX);
        // moves and reports a copy
        send_word(ffba_pkg::CMD_REALLOC, 20'd150, 1'b1, entry_payload(1));
        // fits the register but not the address space
        send_word(ffba_pkg::CMD_ALLOC, '1, 1'b0, '0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [TW-1:0] limit);
        int pick;
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_word(ffba_pkg::CMD_ALLOC, draw_size(), 1'($urandom_range(1)),
                          draw_address());
            else if (pick < 60)
                send_word(ffba_pkg::CMD_FREE, draw_size(), 1'b1, live_address());
            else if (pick < 83)
                send_word(ffba_pkg::CMD_REALLOC, draw_size(), 1'b1, live_address());
            else if (pick < 88)
                send_word(ffba_pkg::CMD_REALLOC, draw_size(), 1'b0, draw_address());
            else if (pick < 96)
                send_word(pick[0] ? ffba_pkg::CMD_FREE : ffba_pkg::CMD_REALLOC, draw_size(),
                          1'($urandom_range(1)), draw_address());
            else
                send_word(CMD_UNUSED, draw_size(), 1'($urandom_range(1)), draw_address());
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        req_ch.valid           = 1'b0;
        req_ch.command         = ffba_pkg::CMD_ALLOC;
        req_ch.request_size    = '0;
        req_ch.address_present = 1'b0;
        req_ch.block_address   = '0;
        rsp_ch.ready           = 1'b0;
        blk_count              = 0;
        top_m                  = '0;
        limit_m                = ffba_pkg::HEAP_LIMIT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_heap();
        test_alloc_free();
        test_realloc();
        test_wide_limit();
        test_random_traffic(0, 0, LIMIT_LOW);
        test_random_traffic(76, 0, '0);
        test_random_traffic(0, 76, LIMIT_MAX);
        test_random_traffic(35, 35, ffba_pkg::HEAP_LIMIT_RESET);

        settle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
sv/ffba_pkg.sv
sv/ffba_req_if.sv
sv/ffba_rsp_if.sv
sv/ffba_table.sv
sv/first_fit_block_allocator.sv
tb/first_fit_block_allocator_test.sv
